FILE: rtl/huffman_preorder_tree_decoder_defines.svh
// Assertion macros for the checker file of the tree decoder
`ifndef HUFFMAN_PREORDER_TREE_DECODER_DEFINES_SVH
`define HUFFMAN_PREORDER_TREE_DECODER_DEFINES_SVH

// same-cycle implication
`define HPTD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HPTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hptd_pkg.sv
// Types and constants shared by the tree decoder modules
`default_nettype none
package hptd_pkg;

   localparam int MAX_NODES_DEF   = 511;
   localparam int STACK_DEPTH_DEF = 256;

   localparam logic [1:0] KIND_SYMBOL = 2'd0;
   localparam logic [1:0] KIND_FINISH = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   localparam logic REG_EOF_SYMBOL = 1'b0;
   localparam logic REG_EOF_ENABLE = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] symbol;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic       valid;
      rsp_type    data;
   } push_type;

   typedef struct packed {
      logic [7:0] eof_symbol;
      logic       eof_enable;
   } cfg_type;

endpackage
`default_nettype wire

FILE: rtl/hptd_queue.sv
// Two-entry valid/ready queue
`default_nettype none
module hptd_queue #(
   parameter type T = logic
) (
   input  wire  clock,
   input  wire  reset,
   input  wire  in_valid,
   output logic in_ready,
   input  T     in_data,
   output logic out_valid,
   input  wire  out_ready,
   output T     out_data
);
   T           ent_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = ent_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/hptd_back.sv
// Bit engine: builds the node table from the header and walks it for data bits
`default_nettype none
module hptd_back #(
   parameter int MAX_NODES   = hptd_pkg::MAX_NODES_DEF,
   parameter int STACK_DEPTH = hptd_pkg::STACK_DEPTH_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  hptd_pkg::cfg_type cfg,
   input  wire               q_valid,
   input  hptd_pkg::req_type q_data,
   output logic              q_pop,
   input  wire               out_full,
   output hptd_pkg::push_type push
);
   localparam int NW = $clog2(MAX_NODES + 1);
   localparam int AW = $clog2(MAX_NODES);
   localparam int SL = $clog2(STACK_DEPTH + 1);
   localparam int SA = $clog2(STACK_DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_BITS  = 4'b0010,
      ST_TAIL  = 4'b0100,
      ST_CLOSE = 4'b1000
   } state_type;

   typedef enum logic [4:0] {
      PH_NODE  = 5'b00001,
      PH_SYM   = 5'b00010,
      PH_DATA  = 5'b00100,
      PH_DONE  = 5'b01000,
      PH_ERROR = 5'b10000
   } phase_type;

   logic          leaf_mem  [MAX_NODES];
   logic [7:0]    sym_mem   [MAX_NODES];
   logic [NW-1:0] right_mem [MAX_NODES];
   logic [NW-1:0] stack_mem [STACK_DEPTH];

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in, phase_eff;
   logic [2:0]       bit_ff, bit_in;
   logic             skip_ff, skip_in;
   logic [SL-1:0]    level_ff, level_in;
   logic [NW-1:0]    nodes_ff, nodes_in;
   logic [NW-1:0]    parent_ff, parent_in, parent_eff;
   logic             side_ff, side_in;
   logic [2:0]       lbits_ff, lbits_in;
   logic [7:0]       shift_ff, shift_in, shift_new;
   logic [NW-1:0]    walk_ff, walk_in, walk_eff;
   logic [NW-1:0]    rw_ff, rw_in, rw_eff;
   logic [NW-1:0]    cur_ff, cur_in, child;
   logic             pend_ff, pend_in;
   logic             popp_ff, popp_in;
   logic [NW-1:0]    rroot_ff, rroot_in;
   logic             rleaf_ff, rleaf_in;
   logic             hold_v_ff, hold_v_in;
   hptd_pkg::rsp_type hold_ff, hold_in;

   logic          leaf_rd_ff;
   logic [7:0]    sym_rd_ff;
   logic [NW-1:0] right_rd_ff;
   logic [NW-1:0] stack_rd_ff;

   logic          node_re, stack_re;
   logic [AW-1:0] node_ra;
   logic [SA-1:0] stack_ra;
   logic          leaf_we, sym_we, right_we, stack_we;
   logic [AW-1:0] leaf_wa, sym_wa, right_wa;
   logic [SA-1:0] stack_wa;
   logic          leaf_wd;

   logic          bit_val, res_emit, res_eof, proc, ovf, new_v, stall;
   hptd_pkg::rsp_type new_r;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      bit_in    = bit_ff;
      skip_in   = skip_ff;
      level_in  = level_ff;
      nodes_in  = nodes_ff;
      parent_in = parent_ff;
      side_in   = side_ff;
      lbits_in  = lbits_ff;
      shift_in  = shift_ff;
      walk_in   = walk_ff;
      rw_in     = rw_ff;
      cur_in    = cur_ff;
      pend_in   = pend_ff;
      popp_in   = popp_ff;
      rroot_in  = rroot_ff;
      rleaf_in  = rleaf_ff;
      hold_v_in = hold_v_ff;
      hold_in   = hold_ff;
      q_pop     = 1'b0;
      push      = '0;
      node_re   = 1'b0;
      stack_re  = 1'b0;
      leaf_we   = 1'b0;
      sym_we    = 1'b0;
      right_we  = 1'b0;
      stack_we  = 1'b0;
      leaf_wd   = 1'b0;
      shift_new = {shift_ff[6:0], 1'b0};
      child     = '0;

      bit_val    = q_data.data_byte[bit_ff];
      parent_eff = popp_ff ? stack_rd_ff : parent_ff;
      node_ra    = '0;
      stack_ra   = SA'(level_ff - SL'(1));
      stack_wa   = level_ff[SA-1:0];
      leaf_wa    = nodes_ff[AW-1:0];
      right_wa   = parent_eff[AW-1:0];
      sym_wa     = AW'(nodes_ff - NW'(1));

      // resolve the pending node-table lookup
      walk_eff = walk_ff;
      rw_eff   = rw_ff;
      res_emit = 1'b0;
      res_eof  = 1'b0;
      if (pend_ff) begin
         if (leaf_rd_ff) begin
            walk_eff = '0;
            rw_eff   = rroot_ff;
            res_emit = 1'b1;
            res_eof  = cfg.eof_enable && (sym_rd_ff == cfg.eof_symbol);
         end else begin
            walk_eff = cur_ff;
            rw_eff   = right_rd_ff;
         end
      end
      phase_eff = res_eof ? PH_DONE : phase_ff;

      proc = (state_ff == ST_BITS) && !skip_ff &&
             (phase_eff == PH_NODE || phase_eff == PH_SYM || phase_eff == PH_DATA);
      ovf  = (nodes_ff >= NW'(MAX_NODES)) ||
             (!bit_val && (level_ff >= SL'(STACK_DEPTH)));

      new_v = 1'b0;
      new_r = '0;
      if ((state_ff == ST_BITS || state_ff == ST_TAIL) && res_emit) begin
         new_v       = 1'b1;
         new_r.kind  = res_eof ? hptd_pkg::KIND_FINISH : hptd_pkg::KIND_SYMBOL;
         new_r.symbol = res_eof ? 8'd0 : sym_rd_ff;
      end else if (proc && phase_eff == PH_NODE && ovf) begin
         new_v      = 1'b1;
         new_r.kind = hptd_pkg::KIND_ERROR;
      end else if (state_ff == ST_TAIL && !pend_ff && q_data.last_byte) begin
         if (phase_ff == PH_NODE || phase_ff == PH_SYM) begin
            new_v      = 1'b1;
            new_r.kind = hptd_pkg::KIND_ERROR;
         end else if (phase_ff == PH_DATA) begin
            new_v      = 1'b1;
            new_r.kind = hptd_pkg::KIND_FINISH;
         end
      end

      stall = out_full && hold_v_ff && (new_v || state_ff == ST_CLOSE);

      if (popp_ff) begin
         parent_in = stack_rd_ff;
         popp_in   = 1'b0;
      end

      if (!stall) begin
         if (state_ff == ST_BITS || state_ff == ST_TAIL) begin
            walk_in  = walk_eff;
            rw_in    = rw_eff;
            pend_in  = 1'b0;
            phase_in = phase_eff;
         end
         if (new_v) begin
            push.valid = hold_v_ff;
            push.data  = hold_ff;
            hold_v_in  = 1'b1;
            hold_in    = new_r;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  state_in = ST_BITS;
                  bit_in   = 3'd7;
                  skip_in  = 1'b0;
               end
            end
            ST_BITS: begin
               if (proc) begin
                  unique case (phase_eff)
                     PH_NODE: begin
                        if (ovf) begin
                           phase_in = PH_ERROR;
                        end else begin
                           leaf_we  = 1'b1;
                           leaf_wd  = bit_val;
                           nodes_in = NW'(nodes_ff + NW'(1));
                           if (nodes_ff == '0) begin
                              rleaf_in = bit_val;
                           end else if (side_ff) begin
                              right_we = 1'b1;
                              if (parent_eff == '0) begin
                                 rroot_in = nodes_ff;
                              end
                           end
                           if (!bit_val) begin
                              stack_we  = 1'b1;
                              level_in  = SL'(level_ff + SL'(1));
                              parent_in = nodes_ff;
                              side_in   = 1'b0;
                           end else begin
                              phase_in = PH_SYM;
                              lbits_in = 3'd0;
                              shift_in = 8'd0;
                           end
                        end
                     end
                     PH_SYM: begin
                        shift_new = {shift_ff[6:0], bit_val};
                        shift_in  = shift_new;
                        if (lbits_ff == 3'd7) begin
                           lbits_in = 3'd0;
                           sym_we   = 1'b1;
                           if (level_ff == '0) begin
                              phase_in = PH_DATA;
                              walk_in  = '0;
                              rw_in    = rroot_ff;
                              skip_in  = 1'b1;
                           end else begin
                              level_in = SL'(level_ff - SL'(1));
                              stack_re = 1'b1;
                              popp_in  = 1'b1;
                              side_in  = 1'b1;
                              phase_in = PH_NODE;
                           end
                        end else begin
                           lbits_in = 3'(lbits_ff + 3'd1);
                        end
                     end
                     PH_DATA: begin
                        if (!rleaf_ff) begin
                           child   = bit_val ? rw_eff : NW'(walk_eff + NW'(1));
                           node_ra = child[AW-1:0];
                           node_re = 1'b1;
                           cur_in  = child;
                           pend_in = 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               if (bit_ff == 3'd0) begin
                  state_in = ST_TAIL;
               end else begin
                  bit_in = 3'(bit_ff - 3'd1);
               end
            end
            ST_TAIL: begin
               if (!pend_ff) begin
                  state_in = ST_CLOSE;
               end
            end
            ST_CLOSE: begin
               push.valid            = hold_v_ff;
               push.data             = hold_ff;
               push.data.last_of_run = 1'b1;
               hold_v_in             = 1'b0;
               q_pop                 = 1'b1;
               state_in              = ST_IDLE;
               if (q_data.last_byte) begin
                  phase_in  = PH_NODE;
                  level_in  = '0;
                  nodes_in  = '0;
                  parent_in = '0;
                  side_in   = 1'b0;
                  lbits_in  = 3'd0;
                  shift_in  = 8'd0;
                  walk_in   = '0;
                  pend_in   = 1'b0;
                  popp_in   = 1'b0;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (leaf_we) begin
         leaf_mem[leaf_wa] <= leaf_wd;
      end
      if (node_re) begin
         leaf_rd_ff <= leaf_mem[node_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem[sym_wa] <= shift_new;
      end
      if (node_re) begin
         sym_rd_ff <= sym_mem[node_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[right_wa] <= nodes_ff;
      end
      if (node_re) begin
         right_rd_ff <= right_mem[node_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= nodes_ff;
      end
      if (stack_re) begin
         stack_rd_ff <= stack_mem[stack_ra];
      end
   end

   always_ff @(posedge clock) begin
      hold_ff  <= hold_in;
      shift_ff <= shift_in;
      cur_ff   <= cur_in;
      rw_ff    <= rw_in;
      rroot_ff <= rroot_in;
      rleaf_ff <= rleaf_in;
      bit_ff   <= bit_in;
      skip_ff  <= skip_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         phase_ff  <= PH_NODE;
         level_ff  <= '0;
         nodes_ff  <= '0;
         parent_ff <= '0;
         side_ff   <= 1'b0;
         lbits_ff  <= 3'd0;
         walk_ff   <= '0;
         pend_ff   <= 1'b0;
         popp_ff   <= 1'b0;
         hold_v_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         level_ff  <= level_in;
         nodes_ff  <= nodes_in;
         parent_ff <= parent_in;
         side_ff   <= side_in;
         lbits_ff  <= lbits_in;
         walk_ff   <= walk_in;
         pend_ff   <= pend_in;
         popp_ff   <= popp_in;
         hold_v_ff <= hold_v_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/huffman_preorder_tree_decoder.sv
// Huffman decoder top level: input queue, bit engine, result queue and registers
// The bit engine takes a stream byte in order: it picks the byte up from the input queue,
// takes one step per bit (a node-table lookup with registered read data), settles the
// lookup of the final data bit when it is still pending (data bytes only), runs the
// end-of-stream check, and then closes the byte and hands over its held result.
// A result waits in a holding register until the next one or the close, and the engine
// stalls while that register and the result queue are full. Bytes queue two deep on the
// input and results two deep on the output, so the source and sink may stall freely. The
// header tree rebuilds after reset and after every last_byte; a stream that ends mid-header
// or whose tree overflows the node table or build stack reports the error kind.
`default_nettype none
module huffman_preorder_tree_decoder #(
   parameter int MAX_NODES   = hptd_pkg::MAX_NODES_DEF,
   parameter int STACK_DEPTH = hptd_pkg::STACK_DEPTH_DEF
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  hptd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output hptd_pkg::rsp_type rsp_data,
   input  wire               psel,
   input  wire               penable,
   input  wire               pwrite,
   input  wire  [2:0]        paddr,
   input  wire  [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   hptd_pkg::cfg_type  cfg_ff, cfg_in;
   hptd_pkg::req_type  q_data;
   hptd_pkg::push_type push;
   logic               q_valid, q_pop, out_ready;
   logic               wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         if (paddr[2] == hptd_pkg::REG_EOF_SYMBOL) begin
            cfg_in.eof_symbol = pwdata[7:0];
         end else begin
            cfg_in.eof_enable = pwdata[0];
         end
      end
      if (paddr[2] == hptd_pkg::REG_EOF_ENABLE) begin
         prdata = {31'd0, cfg_ff.eof_enable};
      end else begin
         prdata = {24'd0, cfg_ff.eof_symbol} | {30'd0, paddr[1:0] & 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.eof_symbol <= 8'd1;
         cfg_ff.eof_enable <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   hptd_queue #(.T(hptd_pkg::req_type)) u_inq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_ready (q_pop),
      .out_data  (q_data)
   );

   hptd_back #(.MAX_NODES(MAX_NODES), .STACK_DEPTH(STACK_DEPTH)) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .q_valid  (q_valid),
      .q_data   (q_data),
      .q_pop    (q_pop),
      .out_full (!out_ready),
      .push     (push)
   );

   hptd_queue #(.T(hptd_pkg::rsp_type)) u_outq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push.valid),
      .in_ready  (out_ready),
      .in_data   (push.data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );
endmodule
`default_nettype wire

FILE: rtl/hptd_checker.sv
// Port-level checks for the tree decoder and their bind
`default_nettype none
`include "huffman_preorder_tree_decoder_defines.svh"
module hptd_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_ready,
   input hptd_pkg::rsp_type rsp_data
);
   `HPTD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result beat changed while stalled")
   `HPTD_ASSERT_IMPLY(a_sym_zero, clock, reset, rsp_valid && rsp_data.kind != hptd_pkg::KIND_SYMBOL, rsp_data.symbol == 8'd0, "status beat carries a symbol")
   `HPTD_ASSERT_IMPLY(a_status_last, clock, reset, rsp_valid && rsp_data.kind != hptd_pkg::KIND_SYMBOL, rsp_data.last_of_run, "status beat not last of its byte")
   `HPTD_ASSERT_IMPLY(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "result beat right after reset")
endmodule

bind huffman_preorder_tree_decoder hptd_checker u_hptd_checker (.*);
`default_nettype wire

FILE: test/huffman_preorder_tree_decoder_test.sv
// Self-checking testbench for the preorder-tree Huffman decoder: random trees, data and idling
`timescale 1ns / 1ps
`default_nettype none
module huffman_preorder_tree_decoder_test;

   localparam int TABLE_SIZE = hptd_pkg::MAX_NODES_DEF;
   localparam int STACK_SIZE = hptd_pkg::STACK_DEPTH_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef enum int {PH_NODE, PH_SYM, PH_DATA, PH_DONE, PH_ERROR} walk_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   hptd_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   hptd_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   huffman_preorder_tree_decoder i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial forever #2 clock = ~clock;

   // decoder state mirror
   bit nd_leaf[TABLE_SIZE];
   bit [8:0] nd_left[TABLE_SIZE];
   bit [8:0] nd_right[TABLE_SIZE];
   bit [7:0] nd_sym[TABLE_SIZE];
   bit [8:0] pend_stack[STACK_SIZE];
   int stack_lvl, nodes_alloc, hook_parent, leaf_bit_cnt, walk_at;
   bit hook_right;
   bit [7:0] sym_shift;
   walk_phase_type phase;
   bit [7:0] end_sym = 8'd1;
   bit end_en = 1'b1;

   hptd_pkg::rsp_type byte_results[$];
   hptd_pkg::rsp_type decoded_q[$];
   hptd_pkg::req_type byte_q[$];
   bit tree_bits[$];

   int errors = 0;
   int beats_in = 0, beats_out = 0, streams = 0;
   int idle_cycles = 0;
   int send_gap = 0, recv_stall = 0;
   bit burst = 1'b0;
   bit req_took = 1'b0;

   task automatic report(string what, hptd_pkg::rsp_type got, hptd_pkg::rsp_type want);
      errors++;
      $display("MISMATCH %s: got kind=%0d sym=%0d last=%0d, want kind=%0d sym=%0d last=%0d",
         what, got.kind, got.symbol, got.last_of_run, want.kind, want.symbol, want.last_of_run);
   endtask

   function automatic void clear_tree();
      for (int i = 0; i < TABLE_SIZE; i++) begin
         nd_leaf[i] = 0; nd_left[i] = 0; nd_right[i] = 0; nd_sym[i] = 0;
      end
      stack_lvl = 0; nodes_alloc = 0; hook_parent = 0; hook_right = 0;
      phase = PH_NODE; leaf_bit_cnt = 0; sym_shift = 0; walk_at = 0;
   endfunction

   function automatic void add_result(logic [1:0] kind, logic [7:0] sym);
      if (byte_results.size() < 9)
         byte_results.insert(byte_results.size(), '{kind, sym, 1'b0});
   endfunction

   function automatic void append_bit(bit b);
      tree_bits.insert(tree_bits.size(), b);
   endfunction

   function automatic void append_byte(hptd_pkg::req_type r);
      byte_q.insert(byte_q.size(), r);
   endfunction

   function automatic bit grab_node(bit is_leaf);
      if (nodes_alloc >= TABLE_SIZE) return 0;
      nd_leaf[nodes_alloc] = is_leaf;
      nd_left[nodes_alloc] = 0; nd_right[nodes_alloc] = 0; nd_sym[nodes_alloc] = 0;
      if (nodes_alloc > 0) begin
         if (!hook_right) nd_left[hook_parent] = nodes_alloc;
         else nd_right[hook_parent] = nodes_alloc;
      end
      nodes_alloc++;
      return 1;
   endfunction

   // returns 1 when the tree has just been completed
   function automatic bit tree_bit(bit b);
      if (phase == PH_NODE) begin
         if (!b) begin
            if (stack_lvl >= STACK_SIZE || !grab_node(0)) begin
               phase = PH_ERROR; add_result(hptd_pkg::KIND_ERROR, 0); return 0;
            end
            pend_stack[stack_lvl] = nodes_alloc - 1;
            stack_lvl++;
            hook_parent = nodes_alloc - 1; hook_right = 0;
         end else begin
            if (!grab_node(1)) begin
               phase = PH_ERROR; add_result(hptd_pkg::KIND_ERROR, 0); return 0;
            end
            phase = PH_SYM; leaf_bit_cnt = 0; sym_shift = 0;
         end
         return 0;
      end
      sym_shift = {sym_shift[6:0], b};
      leaf_bit_cnt++;
      if (leaf_bit_cnt < 8) return 0;
      leaf_bit_cnt = 0;
      nd_sym[nodes_alloc - 1] = sym_shift;
      if (stack_lvl == 0) begin
         phase = PH_DATA; walk_at = 0; return 1;
      end
      stack_lvl--;
      hook_parent = pend_stack[stack_lvl]; hook_right = 1; phase = PH_NODE;
      return 0;
   endfunction

   function automatic void walk_bit(bit b);
      int child;
      if (nodes_alloc == 0 || nd_leaf[0]) return;
      if (walk_at >= nodes_alloc) walk_at = 0;
      child = b ? nd_right[walk_at] : nd_left[walk_at];
      if (child >= nodes_alloc) begin
         walk_at = 0; return;
      end
      if (nd_leaf[child]) begin
         walk_at = 0;
         if (end_en && nd_sym[child] == end_sym) begin
            phase = PH_DONE; add_result(hptd_pkg::KIND_FINISH, 0);
         end else add_result(hptd_pkg::KIND_SYMBOL, nd_sym[child]);
      end else walk_at = child;
   endfunction

   function automatic void decode_byte(hptd_pkg::req_type r);
      byte_results.delete();
      for (int i = 7; i >= 0; i--) begin
         if (phase == PH_NODE || phase == PH_SYM) begin
            if (tree_bit(r.data_byte[i])) break;
         end else if (phase == PH_DATA) walk_bit(r.data_byte[i]);
         else break;
      end
      if (r.last_byte) begin
         if (phase == PH_NODE || phase == PH_SYM) add_result(hptd_pkg::KIND_ERROR, 0);
         else if (phase == PH_DATA) add_result(hptd_pkg::KIND_FINISH, 0);
         clear_tree();
      end
      if (byte_results.size() > 0) byte_results[byte_results.size() - 1].last_of_run = 1'b1;
      foreach (byte_results[i]) decoded_q.insert(decoded_q.size(), byte_results[i]);
   endfunction

   // monitor
   always @(posedge clock) begin
      req_took <= req_valid && req_ready && !reset;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && req_ready) begin
            decode_byte(req_data); beats_in++; idle_cycles = 0;
         end
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0; beats_out++;
            recv_stall = burst ? 0 : $urandom_range(0, 17);
            if (decoded_q.size() == 0) begin
               report("unexpected beat", rsp_data, '0);
            end else begin
               if (rsp_data.kind !== decoded_q[0].kind)
                  report("kind", rsp_data, decoded_q[0]);
               if (rsp_data.symbol !== decoded_q[0].symbol)
                  report("symbol", rsp_data, decoded_q[0]);
               if (rsp_data.last_of_run !== decoded_q[0].last_of_run)
                  report("last_of_run", rsp_data, decoded_q[0]);
               void'(decoded_q.pop_front());
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout with %0d beats still expected", decoded_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_took) begin
            if (send_gap > 0 || byte_q.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               req_data <= byte_q.pop_front();
               req_valid <= 1'b1;
               send_gap = burst ? 0 : $urandom_range(0, 17);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--; rsp_ready <= 1'b0;
         end else rsp_ready <= 1'b1;
      end
   end

   task automatic csr_write(logic addr_sel, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; paddr <= {addr_sel, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr_sel == hptd_pkg::REG_EOF_SYMBOL) end_sym = value[7:0];
      else end_en = value[0];
   endtask

   task automatic drain();
      wait (byte_q.size() == 0 && !req_valid && decoded_q.size() == 0);
      repeat (40) @(posedge clock);
   endtask

   function automatic bit [7:0] pick_sym();
      return ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
   endfunction

   task automatic grow_tree(int depth);
      bit [7:0] s;
      if (depth > 0 && (depth >= 4 || $urandom_range(0, 2) == 0)) begin
         s = pick_sym();
         append_bit(1);
         for (int i = 7; i >= 0; i--) append_bit(s[i]);
      end else begin
         append_bit(0);
         grow_tree(depth + 1);
         grow_tree(depth + 1);
      end
   endtask

   // pack tree_bits plus random padding, then data bytes; cut trims the header
   task automatic queue_stream(int data_bytes, bit cut, bit [7:0] fill, bit fill_random);
      hptd_pkg::req_type r;
      int nbytes;
      while (tree_bits.size() % 8 != 0) append_bit($urandom_range(0, 1));
      nbytes = tree_bits.size() / 8;
      if (cut && nbytes > 1) nbytes = $urandom_range(1, nbytes - 1);
      for (int b = 0; b < nbytes; b++) begin
         for (int i = 0; i < 8; i++) r.data_byte[7 - i] = tree_bits[b * 8 + i];
         r.last_byte = cut ? (b == nbytes - 1) : (data_bytes == 0 && b == nbytes - 1);
         append_byte(r);
      end
      if (!cut) for (int d = 0; d < data_bytes; d++) begin
         r.data_byte = fill_random ? 8'($urandom_range(0, 255)) : fill;
         r.last_byte = (d == data_bytes - 1);
         append_byte(r);
      end
      tree_bits.delete();
      streams++;
   endtask

   task automatic add_leaf(bit [7:0] s);
      append_bit(1);
      for (int i = 7; i >= 0; i--) append_bit(s[i]);
   endtask

   initial begin
      int pick;
      clear_tree();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // single leaf: data emits nothing
      add_leaf(8'hA5); queue_stream(2, 0, 8'hFF, 0);
      // two leaves, right one the end symbol, all-zero then all-ones data
      append_bit(0); add_leaf(8'h00); add_leaf(8'h01);
      queue_stream(2, 0, 8'h00, 0);
      append_bit(0); add_leaf(8'hFF); add_leaf(8'h01);
      queue_stream(2, 0, 8'hFF, 0);
      // header cut short
      append_bit(0); add_leaf(8'h7E); add_leaf(8'h3C);
      queue_stream(0, 1, 8'h00, 0);
      // tree completes exactly at the last byte
      append_bit(0); add_leaf(8'h80); add_leaf(8'h55);
      queue_stream(0, 0, 8'h00, 0);
      // noise stream
      for (int i = 0; i < 3; i++)
         append_byte('{8'($urandom_range(0, 255)), i == 2});
      drain();
      csr_write(hptd_pkg::REG_EOF_ENABLE, 32'd0);
      append_bit(0); add_leaf(8'h01); add_leaf(8'hFE);
      queue_stream(2, 0, 8'h5A, 0);
      // build stack overflow: 264 internal-node bits, more than the 256-entry stack holds
      for (int i = 0; i < 264; i++) append_bit(0);
      queue_stream(0, 0, 8'h00, 0);
      byte_q[byte_q.size() - 1].last_byte = 1'b0;
      append_byte('{8'h00, 1'b1});
      drain();

      for (int cfg = 0; cfg < 4; cfg++) begin
         case (cfg)
            0: begin
               csr_write(hptd_pkg::REG_EOF_SYMBOL, 32'd0);
               csr_write(hptd_pkg::REG_EOF_ENABLE, 32'd1);
            end
            1: begin
               csr_write(hptd_pkg::REG_EOF_SYMBOL, 32'd255);
               csr_write(hptd_pkg::REG_EOF_ENABLE, 32'd1);
            end
            2: begin
               csr_write(hptd_pkg::REG_EOF_SYMBOL, 32'd3);
               csr_write(hptd_pkg::REG_EOF_ENABLE, 32'd0);
            end
            default: begin
               csr_write(hptd_pkg::REG_EOF_SYMBOL, 32'($urandom_range(0, 3)));
               csr_write(hptd_pkg::REG_EOF_ENABLE, 32'd1);
            end
         endcase
         burst = (cfg == 1);
         for (int s = 0; s < 4; s++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               grow_tree(0); queue_stream($urandom_range(1, 6), 0, 8'h00, 1);
            end else if (pick == 7) begin
               grow_tree(0); queue_stream(0, 1, 8'h00, 0);
            end else begin
               for (int i = 0; i < 4; i++)
                  append_byte('{8'($urandom_range(0, 255)), i == 3});
            end
            if (cfg == 0 && s == 1) begin
               // hold the source until every pending beat is out
               wait (byte_q.size() == 0 && !req_valid && decoded_q.size() == 0);
            end
         end
         drain();
      end

      $display("Covered %0d streams, %0d input beats, %0d result beats", streams, beats_in,
         beats_out);
      $display("Included single-leaf, truncated, noise, end-symbol and stack overflow streams");
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
